FILE: hdl/cht_pkg.sv
// shared types and constants for the coalesced hash table
package cht_pkg;

  // power of two, so the home slot is the low bits of the key
  localparam int TABLE_SIZE = 256;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_RESERVED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_END_RD,
    ST_END_CHK,
    ST_UNLINK,
    ST_RESULT
  } state_t;

endpackage

FILE: hdl/coalesced_hash_table.sv
// coalesced hash table: top level with sequencer and slot memories
// steps: each chain slot walked is read and checked; a removed chain end is then unlinked,
//   then each probe slot and each link to its chain end is read and checked; then result
// one transaction at a time: the input stalls until the result register is taken
// reset: after rst a clearing pass writes every slot,
//   during which no transaction is accepted
module coalesced_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [63:0] read_value,
  output logic [1:0]  status
);

  localparam int TABLE_SIZE = cht_pkg::TABLE_SIZE;
  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int WW = AW + 1;

  logic [63:0]   key_mem  [TABLE_SIZE];
  logic [63:0]   data_mem [TABLE_SIZE];
  logic [AW:0]   link_mem [TABLE_SIZE];  // msb is link valid

  cht_pkg::state_t state, state_next;

  logic [1:0]  op_mode;
  logic [63:0] op_key, op_value;
  logic [AW-1:0] slot, pred, tail, free_slot, probe, walk;
  logic has_pred, has_free;
  logic [WW-1:0] cnt, cnt2;   // walk counters, bounded by TABLE_SIZE
  logic [CW-1:0] entry_count;
  logic [AW-1:0] clr_addr;

  // registered read port
  logic [AW-1:0] rd_addr;
  logic [63:0] rd_key, rd_data;
  logic [AW:0] rd_link;

  // single write port per memory
  logic          wr_key_en, wr_data_en, wr_link_en;
  logic [AW-1:0] wr_key_addr, wr_data_addr, wr_link_addr;
  logic [63:0]   wr_key_val, wr_data_val;
  logic [AW:0]   wr_link_val;

  always_ff @(posedge clk) begin
    rd_key  <= key_mem[rd_addr];
    rd_data <= data_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
    if (wr_key_en)  key_mem[wr_key_addr]   <= wr_key_val;
    if (wr_data_en) data_mem[wr_data_addr] <= wr_data_val;
    if (wr_link_en) link_mem[wr_link_addr] <= wr_link_val;
  end

  logic in_acc;
  assign in_stall = (state != cht_pkg::ST_IDLE) || out_valid;
  assign in_acc   = in_valid && !in_stall;

  // result register
  logic res_load;
  logic res_found;
  logic [63:0] res_value;
  logic [1:0] res_status;

  // control signals from sequencer
  logic set_tail, set_free, set_pred, cnt_clr, cnt_inc, cnt2_clr, cnt2_inc;
  logic probe_init, probe_inc, walk_load, cnt_dec, cnt_up;
  logic [AW-1:0] walk_val;

  logic [AW-1:0] next_link;
  assign next_link = rd_link[AW-1:0];

  always_comb begin
    state_next = state;
    rd_addr = slot;
    wr_key_en = 1'b0; wr_data_en = 1'b0; wr_link_en = 1'b0;
    wr_key_addr = slot; wr_data_addr = slot; wr_link_addr = slot;
    wr_key_val = '0; wr_data_val = '0; wr_link_val = '0;
    res_load = 1'b0; res_found = 1'b0; res_value = '0;
    res_status = cht_pkg::STATUS_OK;
    set_tail = 1'b0; set_free = 1'b0; set_pred = 1'b0;
    cnt_clr = 1'b0; cnt_inc = 1'b0; cnt2_clr = 1'b0; cnt2_inc = 1'b0;
    probe_init = 1'b0; probe_inc = 1'b0; walk_load = 1'b0; walk_val = probe;
    cnt_dec = 1'b0; cnt_up = 1'b0;
    case (state)
      cht_pkg::ST_CLEAR: begin
        wr_key_en = 1'b1; wr_data_en = 1'b1; wr_link_en = 1'b1;
        wr_key_addr = clr_addr; wr_data_addr = clr_addr; wr_link_addr = clr_addr;
        if (clr_addr == AW'(TABLE_SIZE - 1)) state_next = cht_pkg::ST_IDLE;
      end
      cht_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (mode == cht_pkg::MODE_NOP || key == 64'd0) state_next = cht_pkg::ST_RESULT;
          else state_next = cht_pkg::ST_WALK_RD;
        end
      end
      cht_pkg::ST_WALK_RD: begin
        rd_addr = slot;
        state_next = cht_pkg::ST_WALK_CHK;
      end
      cht_pkg::ST_WALK_CHK: begin
        if (rd_key == op_key) begin
          case (op_mode)
            cht_pkg::MODE_INSERT: begin
              wr_data_en = 1'b1; wr_data_val = op_value;
              res_load = 1'b1; res_found = 1'b1;
              state_next = cht_pkg::ST_RESULT;
            end
            cht_pkg::MODE_GET: begin
              res_load = 1'b1; res_found = 1'b1; res_value = rd_data;
              state_next = cht_pkg::ST_RESULT;
            end
            default: begin
              wr_key_en = 1'b1; wr_data_en = 1'b1;
              cnt_dec = 1'b1;
              if (!rd_link[AW]) begin
                wr_link_en = 1'b1;
                state_next = has_pred ? cht_pkg::ST_UNLINK : cht_pkg::ST_RESULT;
              end else state_next = cht_pkg::ST_RESULT;
              res_load = 1'b1; res_found = 1'b1;
            end
          endcase
        end else begin
          if (!has_free && rd_key == 64'd0) set_free = 1'b1;
          set_tail = 1'b1;
          cnt_inc = 1'b1;
          if (!rd_link[AW] || cnt == WW'(TABLE_SIZE - 1)) begin
            // miss
            res_load = 1'b1;
            if (op_mode == cht_pkg::MODE_INSERT) begin
              if (entry_count >= CW'(TABLE_SIZE)) begin
                res_status = cht_pkg::STATUS_FULL;
                state_next = cht_pkg::ST_RESULT;
              end else if (!has_free && rd_key == 64'd0) begin
                wr_key_en = 1'b1; wr_key_val = op_key;
                wr_data_en = 1'b1; wr_data_val = op_value;
                cnt_up = 1'b1;
                state_next = cht_pkg::ST_RESULT;
              end else if (has_free) begin
                wr_key_en = 1'b1; wr_key_val = op_key; wr_key_addr = free_slot;
                wr_data_en = 1'b1; wr_data_val = op_value; wr_data_addr = free_slot;
                cnt_up = 1'b1;
                state_next = cht_pkg::ST_RESULT;
              end else begin
                probe_init = 1'b1;
                state_next = cht_pkg::ST_PROBE_RD;
              end
            end else state_next = cht_pkg::ST_RESULT;
          end else begin
            set_pred = 1'b1;
            state_next = cht_pkg::ST_WALK_RD;
          end
        end
      end
      cht_pkg::ST_PROBE_RD: begin
        rd_addr = probe;
        state_next = cht_pkg::ST_PROBE_CHK;
      end
      cht_pkg::ST_PROBE_CHK: begin
        if (rd_key == 64'd0) begin
          walk_load = 1'b1; walk_val = probe;
          cnt2_clr = 1'b1;
          if (!rd_link[AW]) begin
            if (probe != tail) begin
              wr_link_en = 1'b1; wr_link_addr = tail; wr_link_val = {1'b1, probe};
              wr_key_en = 1'b1; wr_key_addr = probe; wr_key_val = op_key;
              wr_data_en = 1'b1; wr_data_addr = probe; wr_data_val = op_value;
              cnt_up = 1'b1;
              res_load = 1'b1;
              state_next = cht_pkg::ST_RESULT;
            end else begin
              probe_inc = 1'b1; cnt_inc = 1'b1;
              state_next = (cnt == WW'(TABLE_SIZE - 1)) ? cht_pkg::ST_RESULT
                                                         : cht_pkg::ST_PROBE_RD;
              if (cnt == WW'(TABLE_SIZE - 1)) res_status = cht_pkg::STATUS_FULL;
              res_load = 1'b1;
            end
          end else begin
            walk_val = next_link; cnt2_inc = 1'b1;
            state_next = cht_pkg::ST_END_RD;
          end
        end else begin
          probe_inc = 1'b1; cnt_inc = 1'b1;
          res_load = 1'b1; res_status = cht_pkg::STATUS_FULL;
          state_next = (cnt == WW'(TABLE_SIZE - 1)) ? cht_pkg::ST_RESULT
                                                     : cht_pkg::ST_PROBE_RD;
        end
      end
      cht_pkg::ST_END_RD: begin
        rd_addr = walk;
        state_next = cht_pkg::ST_END_CHK;
      end
      cht_pkg::ST_END_CHK: begin
        if (!rd_link[AW] || cnt2 == WW'(TABLE_SIZE)) begin
          if (walk != tail) begin
            wr_link_en = 1'b1; wr_link_addr = tail; wr_link_val = {1'b1, probe};
            wr_key_en = 1'b1; wr_key_addr = probe; wr_key_val = op_key;
            wr_data_en = 1'b1; wr_data_addr = probe; wr_data_val = op_value;
            cnt_up = 1'b1;
            res_load = 1'b1;
            state_next = cht_pkg::ST_RESULT;
          end else begin
            probe_inc = 1'b1; cnt_inc = 1'b1;
            res_load = 1'b1; res_status = cht_pkg::STATUS_FULL;
            state_next = (cnt == WW'(TABLE_SIZE - 1)) ? cht_pkg::ST_RESULT
                                                       : cht_pkg::ST_PROBE_RD;
          end
        end else begin
          walk_load = 1'b1; walk_val = next_link; cnt2_inc = 1'b1;
          state_next = cht_pkg::ST_END_RD;
        end
      end
      cht_pkg::ST_UNLINK: begin
        // drop the predecessor's link, keeping its index bits
        wr_link_en = 1'b1; wr_link_addr = pred;
        wr_link_val = {1'b0, slot};
        state_next = cht_pkg::ST_RESULT;
      end
      cht_pkg::ST_RESULT: begin
        if (!(out_valid && out_stall)) state_next = cht_pkg::ST_IDLE;
      end
      default: state_next = cht_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cht_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      entry_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == cht_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (cnt_up) entry_count <= entry_count + CW'(1);
      else if (cnt_dec && entry_count != '0) entry_count <= entry_count - CW'(1);
      if (state == cht_pkg::ST_RESULT && !(out_valid && out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_mode <= mode; op_key <= key; op_value <= value;
      slot <= key[AW-1:0];
      has_pred <= 1'b0; has_free <= 1'b0;
      cnt <= '0;
      found <= 1'b0; read_value <= '0;
      status <= (mode != cht_pkg::MODE_NOP && key == 64'd0) ? cht_pkg::STATUS_RESERVED
                                                              : cht_pkg::STATUS_OK;
    end else begin
      if (res_load) begin
        found <= res_found; read_value <= res_value; status <= res_status;
      end
      if (set_free) begin free_slot <= slot; has_free <= 1'b1; end
      if (set_tail) tail <= slot;
      if (set_pred) begin
        pred <= slot; has_pred <= 1'b1; slot <= next_link;
      end
      if (probe_init) begin
        probe <= slot + AW'(1); cnt <= WW'(1);
      end else if (cnt_inc) cnt <= cnt + WW'(1);
      if (probe_inc) probe <= probe + AW'(1);
      if (walk_load) walk <= walk_val;
      if (cnt2_clr) cnt2 <= WW'(1);
      else if (cnt2_inc) cnt2 <= cnt2 + WW'(1);
    end
  end

endmodule
